FILE: src/irn_pkg.sv
`timescale 1ns / 1ps

package irn_pkg;

  localparam int VAL_W = 13;
  localparam int SYM_W = 8;
  localparam int NTOK  = 13;
  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(4999);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [3:0]       tok_t;

  localparam sym_t CH_I = 8'h49;
  localparam sym_t CH_V = 8'h56;
  localparam sym_t CH_X = 8'h58;
  localparam sym_t CH_L = 8'h4C;
  localparam sym_t CH_C = 8'h43;
  localparam sym_t CH_D = 8'h44;
  localparam sym_t CH_M = 8'h4D;
  localparam sym_t CH_NONE = 8'h00;

  // greedy token table, largest weight first
  localparam val_t TOK_W [NTOK] = '{
    13'd1000, 13'd900, 13'd500, 13'd400, 13'd100, 13'd90, 13'd50,
    13'd40, 13'd10, 13'd9, 13'd5, 13'd4, 13'd1
  };
  localparam sym_t TOK_A [NTOK] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  localparam sym_t TOK_B [NTOK] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };
  localparam logic TOK_PAIR [NTOK] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

  typedef struct packed {
    logic load;
    logic step;
  } irn_cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_last;
  } irn_stat_t;

  // largest token not above v
  function automatic tok_t pick_tok(input val_t v);
    tok_t t;
    t = tok_t'(NTOK - 1);
    for (int i = NTOK - 1; i >= 0; i--) begin
      if (v >= TOK_W[i]) t = tok_t'(i);
    end
    return t;
  endfunction

endpackage

FILE: src/irn_if.sv
`timescale 1ns / 1ps

interface irn_in_if;
  logic                 valid;
  logic                 ready;
  logic [12:0]          value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface irn_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           symbol;
  logic                 empty_res;
  logic                 last;
  modport source (output valid, output symbol, output empty_res, output last,
                  input ready);
  modport sink   (input valid, input symbol, input empty_res, input last,
                  output ready);
endinterface

FILE: src/irn_ctrl.sv
`timescale 1ns / 1ps

module irn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  irn_pkg::irn_stat_t stat,
  output irn_pkg::irn_cmd_t  cmd
);
  import irn_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state_r == ST_EMIT) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.load) state_nxt = ST_EMIT;
      ST_EMIT: if (cmd.step && stat.step_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/irn_dp.sv
`timescale 1ns / 1ps

module irn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  irn_pkg::val_t      in_value,
  input  irn_pkg::irn_cmd_t  cmd,
  output irn_pkg::irn_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output irn_pkg::sym_t      out_symbol,
  output logic               out_empty_res,
  output logic               out_last
);
  import irn_pkg::*;

  val_t v_r, v_nxt;
  logic pend_r, pend_nxt;
  sym_t pend_sym_r, pend_sym_nxt;
  sym_t sym_r, sym_nxt;
  logic empty_r, empty_nxt;
  logic last_r, last_nxt;
  logic ovalid_r;
  tok_t tok;

  assign tok = pick_tok(v_r);

  always_comb begin
    v_nxt        = v_r;
    pend_nxt     = 1'b0;
    pend_sym_nxt = TOK_B[tok];
    sym_nxt      = CH_NONE;
    empty_nxt    = 1'b0;
    last_nxt     = 1'b0;
    priority if (pend_r) begin
      // second letter of a subtractive pair
      sym_nxt  = pend_sym_r;
      last_nxt = (v_r == '0);
    end else if (v_r == '0) begin
      empty_nxt = 1'b1;
      last_nxt  = 1'b1;
    end else begin
      sym_nxt  = TOK_A[tok];
      v_nxt    = v_r - TOK_W[tok];
      pend_nxt = TOK_PAIR[tok];
      last_nxt = !TOK_PAIR[tok] && (v_nxt == '0);
    end
  end

  assign stat.step_last = last_nxt;
  assign stat.out_free  = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_r <= 1'b0;
      end else if (cmd.step) begin
        pend_r <= pend_nxt;
      end
      if (cmd.step) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= (in_value > VAL_MAX) ? VAL_MAX : in_value;
    end else if (cmd.step) begin
      v_r        <= v_nxt;
      pend_sym_r <= pend_sym_nxt;
    end
    if (cmd.step) begin
      sym_r   <= sym_nxt;
      empty_r <= empty_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_symbol    = sym_r;
  assign out_empty_res = empty_r;
  assign out_last      = last_r;

endmodule

FILE: src/int_to_roman_numeral.sv
`timescale 1ns / 1ps
// channel   dir  payload                          handshake
// in_ch     in   value[12:0]                      valid/ready
// out_ch    out  symbol[7:0], empty_res, last     valid/ready
//
// an item is taken while idle, then one result per cycle while out_ch.ready lets the output register move on
// the letter count of the numeral sets how long an item takes, longest is 4888 with 16 letters
// synchronous active-low reset clears the state machine and output valid
// out_ch.ready low holds the output register and stops the letter sequencer
// the next item is taken once the last letter sits in the output register

module int_to_roman_numeral (
  input  logic      clk,
  input  logic      rst_n,
  irn_in_if.sink    in_ch,
  irn_out_if.source out_ch
);
  import irn_pkg::*;

  irn_cmd_t  cmd;
  irn_stat_t stat;
  logic      in_ready;

  // controller: idle until an item arrives, then steps the sequencer
  irn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath: remaining value, greedy token pick, pending pair letter, output register
  irn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_symbol    (out_ch.symbol),
    .out_empty_res (out_ch.empty_res),
    .out_last      (out_ch.last)
  );

endmodule
